// ----- rtl/core/mpts_pkg.sv -----
package mpts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int EVENT_CAP     = 16;

    localparam logic [1:0] OP_ARRIVE   = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;

    localparam logic [1:0] REG_POLICY       = 2'd0;
    localparam logic [1:0] REG_SLICE_LENGTH = 2'd1;
    localparam logic [1:0] REG_WORKER_TOTAL = 2'd2;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_STOPPED = 2'd2;

    localparam logic [1:0] POLICY_RST       = POL_FCFS;
    localparam logic [7:0] SLICE_RST        = 8'd5;
    localparam logic [4:0] WORKER_TOTAL_RST = 5'd4;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_START   = 3'd1,
        EV_FINISH  = 3'd2,
        EV_PREEMPT = 3'd3,
        EV_REJECT  = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE, S_ARRIVE, S_TICK, S_FCFS, S_SJF, S_RR, S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        M_NONE, M_ARRIVE, M_TICK, M_FCFS, M_SJF, M_RR
    } t_mode;

    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] remaining;
        logic [1:0]  status;
        logic        in_slice;
        logic [7:0]  slice_left;
    } t_entry;

    typedef struct packed {
        logic  load;
        t_mode mode;
        logic  final_push;
    } t_cmd;

    typedef struct packed {
        logic       slot_free;
        logic       tick_end;
        logic       disp_end;
        logic       sjf_end;
        logic [1:0] policy;
    } t_status;

endpackage

// ----- rtl/core/mpts_ctrl.sv -----
module mpts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_op,
    input  mpts_pkg::t_status i_status,
    output mpts_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);
    import mpts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_op == OP_ARRIVE) begin
                        n_state = S_ARRIVE;
                    end else if (i_op == OP_TICK) begin
                        n_state = S_TICK;
                    end else if (i_op == OP_DISPATCH && i_status.policy == POL_FCFS) begin
                        n_state = S_FCFS;
                    end else if (i_op == OP_DISPATCH && i_status.policy == POL_SJF) begin
                        n_state = S_SJF;
                    end else if (i_op == OP_DISPATCH && i_status.policy == POL_RR) begin
                        n_state = S_RR;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_ARRIVE: n_state = S_FINISH;
            S_TICK:   if (i_status.tick_end) n_state = S_FINISH;
            S_FCFS:   if (i_status.disp_end) n_state = S_FINISH;
            S_RR:     if (i_status.disp_end) n_state = S_FINISH;
            S_SJF:    if (i_status.sjf_end)  n_state = S_FINISH;
            S_FINISH: if (i_status.slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '{load: 1'b0, mode: M_NONE, final_push: 1'b0};
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_ARRIVE: o_cmd.mode = M_ARRIVE;
            S_TICK: begin
                if (!i_status.tick_end && i_status.slot_free) o_cmd.mode = M_TICK;
            end
            S_FCFS: begin
                if (!i_status.disp_end && i_status.slot_free) o_cmd.mode = M_FCFS;
            end
            S_RR: begin
                if (!i_status.disp_end && i_status.slot_free) o_cmd.mode = M_RR;
            end
            S_SJF: begin
                if (!i_status.sjf_end && i_status.slot_free) o_cmd.mode = M_SJF;
            end
            S_FINISH: o_cmd.final_push = i_status.slot_free;
            default: o_cmd.mode = M_NONE;
        endcase
    end

endmodule

// ----- rtl/core/mpts_dpath.sv -----
module mpts_dpath #(
    parameter int MAX_TASKS = mpts_pkg::MAX_TASKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpts_pkg::t_cmd    i_cmd,
    output mpts_pkg::t_status o_status,
    input  logic [15:0]       i_task_id,
    input  logic [15:0]       i_run_time,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [2:0]        o_event_kind,
    output logic [15:0]       o_task_ident,
    output logic [15:0]       o_time_value,
    output logic [4:0]        o_occupancy,
    output logic [4:0]        o_workers_free,
    output logic              o_last
);
    import mpts_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = $clog2(MAX_TASKS);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);
    localparam logic [4:0] CAP = 5'(EVENT_CAP);

    t_entry r_tab [MAX_TASKS];
    t_entry n_tab [MAX_TASKS];

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [4:0]    r_free, n_free;
    logic [4:0]    r_n, n_n;
    logic          r_found, n_found;
    logic [IW-1:0] r_best, n_best;
    logic [15:0]   r_best_rem, n_best_rem;
    logic [15:0]   r_id, r_rt;
    logic [1:0]    r_policy;
    logic [7:0]    r_slice;
    logic [4:0]    r_total;

    logic          r_pend_valid;
    t_event        r_pend_kind;
    logic [15:0]   r_pend_id, r_pend_time;
    logic [4:0]    r_pend_occ, r_pend_free;

    logic          r_out_valid;
    logic [2:0]    r_out_kind;
    logic [15:0]   r_out_id, r_out_time;
    logic [4:0]    r_out_occ, r_out_free;
    logic          r_out_last;

    logic          ev_make;
    t_event        ev_kind;
    logic [15:0]   ev_id, ev_time;

    logic          slot_free;
    logic [IW-1:0] ix;
    t_entry        cur;
    t_entry        moved;
    t_entry        best_ent;
    logic [7:0]    sl;
    logic [7:0]    sl_dec;
    logic [15:0]   rem_dec;
    logic [15:0]   rt_fix;
    logic          shift_en;
    logic [CW-1:0] tail;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign ix        = r_idx[IW-1:0];
    assign cur       = r_tab[ix];
    assign best_ent  = r_tab[r_best];
    assign sl        = (r_slice == 8'd0) ? 8'd1 : r_slice;
    assign sl_dec    = cur.slice_left - 8'd1;
    assign rem_dec   = (cur.remaining != 16'd0) ? cur.remaining - 16'd1 : 16'd0;
    assign rt_fix    = (r_rt == 16'd0) ? 16'd1 : r_rt;
    assign tail      = r_count - CW'(1);

    assign o_status.slot_free = slot_free;
    assign o_status.tick_end  = !(r_idx < r_count && r_free < r_total && r_n < CAP);
    assign o_status.disp_end  = !(r_idx < r_count && r_free != 5'd0 && r_n < CAP);
    assign o_status.sjf_end   = r_free == 5'd0 || r_n >= CAP || (r_idx >= r_count && !r_found);
    assign o_status.policy    = r_policy;

    always_comb begin
        n_tab      = r_tab;
        n_count    = r_count;
        n_idx      = r_idx;
        n_free     = r_free;
        n_n        = r_n;
        n_found    = r_found;
        n_best     = r_best;
        n_best_rem = r_best_rem;
        ev_make    = 1'b0;
        ev_kind    = EV_NONE;
        ev_id      = cur.ident;
        ev_time    = cur.remaining;
        shift_en   = 1'b0;
        moved      = cur;
        unique case (i_cmd.mode)
            M_ARRIVE: begin
                ev_make = 1'b1;
                ev_id   = r_id;
                ev_time = rt_fix;
                if (r_count < MAX_CNT) begin
                    n_tab[r_count[IW-1:0]] = '{ident: r_id, remaining: rt_fix,
                        status: ST_READY, in_slice: 1'b0, slice_left: 8'd0};
                    n_count = r_count + CW'(1);
                    ev_kind = EV_NONE;
                end else begin
                    ev_kind = EV_REJECT;
                end
            end
            M_TICK: begin
                if (cur.status != ST_RUNNING) begin
                    n_idx = r_idx + CW'(1);
                end else if (r_policy == POL_RR && cur.in_slice) begin
                    n_tab[ix].slice_left = sl_dec;
                    n_idx = r_idx + CW'(1);
                    if (sl_dec == 8'd0) begin
                        n_tab[ix].in_slice = 1'b0;
                        n_tab[ix].status   = ST_STOPPED;
                        n_free  = (r_free < r_total) ? r_free + 5'd1 : r_free;
                        ev_make = 1'b1;
                        ev_kind = EV_PREEMPT;
                    end
                end else if (rem_dec == 16'd0) begin
                    shift_en = 1'b1;
                    n_count  = r_count - CW'(1);
                    n_free   = (r_free < r_total) ? r_free + 5'd1 : r_free;
                    ev_make  = 1'b1;
                    ev_kind  = EV_FINISH;
                    ev_time  = 16'd0;
                end else begin
                    n_tab[ix].remaining = rem_dec;
                    n_idx = r_idx + CW'(1);
                end
            end
            M_FCFS: begin
                n_idx = r_idx + CW'(1);
                if (cur.status == ST_READY) begin
                    n_tab[ix].status = ST_RUNNING;
                    n_free  = r_free - 5'd1;
                    ev_make = 1'b1;
                    ev_kind = EV_START;
                end
            end
            M_SJF: begin
                if (r_idx < r_count) begin
                    n_idx = r_idx + CW'(1);
                    if (cur.status == ST_READY && (!r_found || cur.remaining < r_best_rem)) begin
                        n_found    = 1'b1;
                        n_best     = ix;
                        n_best_rem = cur.remaining;
                    end
                end else begin
                    n_tab[r_best].status = ST_RUNNING;
                    n_free  = r_free - 5'd1;
                    ev_make = 1'b1;
                    ev_kind = EV_START;
                    ev_id   = best_ent.ident;
                    ev_time = best_ent.remaining;
                    n_idx   = '0;
                    n_found = 1'b0;
                end
            end
            M_RR: begin
                if (cur.status == ST_READY || cur.status == ST_STOPPED) begin
                    n_free  = r_free - 5'd1;
                    ev_make = 1'b1;
                    ev_kind = EV_START;
                    if (cur.remaining > {8'd0, sl}) begin
                        moved.remaining  = cur.remaining - {8'd0, sl};
                        moved.status     = ST_RUNNING;
                        moved.in_slice   = 1'b1;
                        moved.slice_left = sl;
                        shift_en = 1'b1;
                        ev_time  = {8'd0, sl};
                    end else begin
                        n_tab[ix].status   = ST_RUNNING;
                        n_tab[ix].in_slice = 1'b0;
                        n_idx = r_idx + CW'(1);
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: n_idx = r_idx;
        endcase
        if (shift_en) begin
            for (int j = 0; j < MAX_TASKS - 1; j++) begin
                if (CW'(j) >= r_idx && CW'(j + 1) < r_count) begin
                    n_tab[j] = r_tab[j + 1];
                end
            end
            if (i_cmd.mode == M_RR) begin
                n_tab[tail[IW-1:0]] = moved;
            end
        end
        if (ev_make) begin
            n_n = r_n + 5'd1;
        end
        if (i_cmd.load) begin
            n_idx   = '0;
            n_n     = 5'd0;
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tab      <= n_tab;
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_best     <= n_best;
        r_best_rem <= n_best_rem;
        if (i_cmd.load) begin
            r_id <= i_task_id;
            r_rt <= i_run_time;
        end
        if (ev_make) begin
            r_pend_kind <= ev_kind;
            r_pend_id   <= ev_id;
            r_pend_time <= ev_time;
            r_pend_occ  <= 5'(n_count);
            r_pend_free <= n_free;
        end
        if (ev_make && r_pend_valid) begin
            r_out_kind <= r_pend_kind;
            r_out_id   <= r_pend_id;
            r_out_time <= r_pend_time;
            r_out_occ  <= r_pend_occ;
            r_out_free <= r_pend_free;
            r_out_last <= 1'b0;
        end else if (i_cmd.final_push) begin
            r_out_kind <= r_pend_valid ? r_pend_kind : EV_NONE;
            r_out_id   <= r_pend_valid ? r_pend_id : 16'd0;
            r_out_time <= r_pend_valid ? r_pend_time : 16'd0;
            r_out_occ  <= r_pend_valid ? r_pend_occ : 5'(r_count);
            r_out_free <= r_pend_valid ? r_pend_free : r_free;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_free       <= WORKER_TOTAL_RST;
            r_found      <= 1'b0;
            r_policy     <= POLICY_RST;
            r_slice      <= SLICE_RST;
            r_total      <= WORKER_TOTAL_RST;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_free  <= n_free;
            r_found <= n_found;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_POLICY:       r_policy <= i_cfg_data[1:0];
                    REG_SLICE_LENGTH: r_slice  <= i_cfg_data;
                    REG_WORKER_TOTAL: r_total  <= i_cfg_data[4:0];
                    default:          r_policy <= r_policy;
                endcase
            end
            if (i_cmd.load || i_cmd.final_push) begin
                r_pend_valid <= 1'b0;
            end else if (ev_make) begin
                r_pend_valid <= 1'b1;
            end
            if ((ev_make && r_pend_valid) || i_cmd.final_push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_task_ident   = r_out_id;
    assign o_time_value   = r_out_time;
    assign o_occupancy    = r_out_occ;
    assign o_workers_free = r_out_free;
    assign o_last         = r_out_last;

endmodule

// ----- rtl/core/multi_policy_task_scheduler_unit.sv -----
// Steps: a no-op goes from acceptance to its final beat and an arrival passes through the
// ARRIVE state first; a tick or dispatch visits table entries in turn, each SJF pick a full scan.
// Flow: one item at a time; a new item is accepted once the last beat of the previous
// one has been registered, and a tick or dispatch pauses while a pending output beat is stalled.
// Reset: synchronous, active low; empties the table, restores the register defaults and
// sets the free worker count to the default worker total.
module multi_policy_task_scheduler_unit #(
    parameter int MAX_TASKS = mpts_pkg::MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_task_id,
    input  logic [15:0] i_run_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_task_ident,
    output logic [15:0] o_time_value,
    output logic [4:0]  o_occupancy,
    output logic [4:0]  o_workers_free,
    output logic        o_last
);
    import mpts_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    mpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mpts_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_task_id      (i_task_id),
        .i_run_time     (i_run_time),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_event_kind   (o_event_kind),
        .o_task_ident   (o_task_ident),
        .o_time_value   (o_time_value),
        .o_occupancy    (o_occupancy),
        .o_workers_free (o_workers_free),
        .o_last         (o_last)
    );

endmodule

// ----- tb/mpts_checker.sv -----
`timescale 1ns / 1ps

module mpts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_task_id,
    input  logic [15:0] i_run_time,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_kind,
    input  logic [15:0] i_task_ident,
    input  logic [15:0] i_time_value,
    input  logic [4:0]  i_occupancy,
    input  logic [4:0]  i_workers_free,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);
    import mpts_pkg::*;

    localparam int TABLE_DEPTH = 16;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] ident;
        logic [15:0] tval;
        logic [4:0]  occ;
        logic [4:0]  free;
        logic        last;
    } t_sched_event;

    t_sched_event expected_events[$];
    t_sched_event item_events[$];

    logic [15:0] tbl_ident [TABLE_DEPTH];
    logic [15:0] tbl_rem   [TABLE_DEPTH];
    logic [1:0]  tbl_status[TABLE_DEPTH];
    logic        tbl_in_sl [TABLE_DEPTH];
    logic [7:0]  tbl_sl_left[TABLE_DEPTH];
    int          tbl_count;
    int          free_cnt;
    logic [1:0]  cur_policy;
    logic [7:0]  cur_slice;
    logic [4:0]  cur_total;

    function automatic void note_event(logic [2:0] kind, logic [15:0] id, logic [15:0] tv);
        t_sched_event e;
        e.kind  = kind;
        e.ident = id;
        e.tval  = tv;
        e.occ   = tbl_count[4:0];
        e.free  = free_cnt[4:0];
        e.last  = 1'b0;
        item_events.push_back(e);
    endfunction

    function automatic void remove_entry(int i);
        for (int j = i; j + 1 < tbl_count; j++) begin
            tbl_ident[j]   = tbl_ident[j+1];
            tbl_rem[j]     = tbl_rem[j+1];
            tbl_status[j]  = tbl_status[j+1];
            tbl_in_sl[j]   = tbl_in_sl[j+1];
            tbl_sl_left[j] = tbl_sl_left[j+1];
        end
        if (tbl_count > 0) tbl_count--;
    endfunction

    function automatic void rotate_to_tail(int i);
        logic [15:0] id, rem;
        logic [1:0]  st;
        logic        ins;
        logic [7:0]  sl;
        id = tbl_ident[i]; rem = tbl_rem[i]; st = tbl_status[i];
        ins = tbl_in_sl[i]; sl = tbl_sl_left[i];
        remove_entry(i);
        tbl_ident[tbl_count] = id; tbl_rem[tbl_count] = rem; tbl_status[tbl_count] = st;
        tbl_in_sl[tbl_count] = ins; tbl_sl_left[tbl_count] = sl;
        tbl_count++;
    endfunction

    function automatic void free_worker();
        if (free_cnt < cur_total) free_cnt++;
    endfunction

    function automatic void advance_tick();
        int i;
        logic [15:0] id;
        i = 0;
        while (i < tbl_count && free_cnt < cur_total && item_events.size() < EVENT_CAP) begin
            if (tbl_status[i] != ST_RUNNING) begin
                i++;
            end else if (cur_policy == POL_RR && tbl_in_sl[i]) begin
                tbl_sl_left[i] = tbl_sl_left[i] - 8'd1;
                if (tbl_sl_left[i] == 8'd0) begin
                    tbl_in_sl[i] = 1'b0;
                    tbl_status[i] = ST_STOPPED;
                    free_worker();
                    note_event(EV_PREEMPT, tbl_ident[i], tbl_rem[i]);
                end
                i++;
            end else begin
                if (tbl_rem[i] > 0) tbl_rem[i] = tbl_rem[i] - 16'd1;
                if (tbl_rem[i] == 0) begin
                    id = tbl_ident[i];
                    remove_entry(i);
                    free_worker();
                    note_event(EV_FINISH, id, 16'd0);
                end else begin
                    i++;
                end
            end
        end
    endfunction

    function automatic void start_in_order();
        for (int i = 0; i < tbl_count && free_cnt > 0 && item_events.size() < EVENT_CAP;
             i++) begin
            if (tbl_status[i] == ST_READY) begin
                tbl_status[i] = ST_RUNNING;
                free_cnt--;
                note_event(EV_START, tbl_ident[i], tbl_rem[i]);
            end
        end
    endfunction

    function automatic void start_shortest();
        int best;
        while (free_cnt > 0 && item_events.size() < EVENT_CAP) begin
            best = -1;
            for (int i = 0; i < tbl_count; i++) begin
                if (tbl_status[i] == ST_READY && (best < 0 || tbl_rem[i] < tbl_rem[best]))
                    best = i;
            end
            if (best < 0) break;
            tbl_status[best] = ST_RUNNING;
            free_cnt--;
            note_event(EV_START, tbl_ident[best], tbl_rem[best]);
        end
    endfunction

    function automatic void start_round_robin();
        int i;
        logic [15:0] sl, rem, id;
        i = 0;
        sl = (cur_slice == 0) ? 16'd1 : {8'd0, cur_slice};
        while (i < tbl_count && free_cnt > 0 && item_events.size() < EVENT_CAP) begin
            if (tbl_status[i] == ST_READY || tbl_status[i] == ST_STOPPED) begin
                rem = tbl_rem[i];
                id = tbl_ident[i];
                free_cnt--;
                tbl_status[i] = ST_RUNNING;
                if (rem > sl) begin
                    tbl_rem[i] = rem - sl;
                    tbl_in_sl[i] = 1'b1;
                    tbl_sl_left[i] = sl[7:0];
                    rotate_to_tail(i);
                    note_event(EV_START, id, sl);
                    continue;
                end
                tbl_in_sl[i] = 1'b0;
                note_event(EV_START, id, rem);
            end
            i++;
        end
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [15:0] id, logic [15:0] rt);
        item_events.delete();
        if (op == OP_ARRIVE) begin
            if (rt == 0) rt = 16'd1;
            if (tbl_count < TABLE_DEPTH) begin
                tbl_ident[tbl_count] = id; tbl_rem[tbl_count] = rt;
                tbl_status[tbl_count] = ST_READY; tbl_in_sl[tbl_count] = 1'b0;
                tbl_sl_left[tbl_count] = 8'd0;
                tbl_count++;
                note_event(EV_NONE, id, rt);
            end else begin
                note_event(EV_REJECT, id, rt);
            end
        end else if (op == OP_TICK) begin
            advance_tick();
        end else if (op == OP_DISPATCH) begin
            if (cur_policy == POL_FCFS) start_in_order();
            else if (cur_policy == POL_SJF) start_shortest();
            else if (cur_policy == POL_RR) start_round_robin();
        end
        if (item_events.size() == 0) note_event(EV_NONE, 16'd0, 16'd0);
        item_events[item_events.size()-1].last = 1'b1;
        foreach (item_events[k]) expected_events.push_back(item_events[k]);
    endfunction

    always @(posedge i_clk) begin
        t_sched_event e;
        if (!i_rst_n) begin
            tbl_count  = 0;
            cur_policy = POLICY_RST;
            cur_slice  = SLICE_RST;
            cur_total  = WORKER_TOTAL_RST;
            free_cnt   = WORKER_TOTAL_RST;
            expected_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_POLICY) cur_policy = i_cfg_data[1:0];
                else if (i_cfg_index == REG_SLICE_LENGTH) cur_slice = i_cfg_data;
                else if (i_cfg_index == REG_WORKER_TOTAL) cur_total = i_cfg_data[4:0];
            end
            if (i_in_valid && !i_in_stall) predict_item(i_op, i_task_id, i_run_time);
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result beat: kind %0d ident %0d",
                           i_event_kind, i_task_ident);
                    o_errors++;
                end else begin
                    e = expected_events.pop_front();
                    if (i_event_kind !== e.kind) begin
                        $error("event_kind: expected %0d actual %0d", e.kind, i_event_kind);
                        o_errors++;
                    end
                    if (i_task_ident !== e.ident) begin
                        $error("task_ident: expected %0d actual %0d", e.ident, i_task_ident);
                        o_errors++;
                    end
                    if (i_time_value !== e.tval) begin
                        $error("time_value: expected %0d actual %0d", e.tval, i_time_value);
                        o_errors++;
                    end
                    if (i_occupancy !== e.occ) begin
                        $error("occupancy: expected %0d actual %0d", e.occ, i_occupancy);
                        o_errors++;
                    end
                    if (i_workers_free !== e.free) begin
                        $error("workers_free: expected %0d actual %0d", e.free,
                               i_workers_free);
                        o_errors++;
                    end
                    if (i_last !== e.last) begin
                        $error("last: expected %0d actual %0d", e.last, i_last);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_events.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end
endmodule

// ----- tb/multi_policy_task_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps

module multi_policy_task_scheduler_unit_tb;
    import mpts_pkg::*;

    localparam logic [1:0] OP_NOP     = 2'd3;
    localparam logic [1:0] POL_NONE   = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         QUIET_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = OP_ARRIVE;
    logic [15:0] i_task_id = '0;
    logic [15:0] i_run_time = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_POLICY;
    logic [7:0]  i_cfg_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_event_kind;
    logic [15:0] o_task_ident;
    logic [15:0] o_time_value;
    logic [4:0]  o_occupancy;
    logic [4:0]  o_workers_free;
    logic        o_last;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    multi_policy_task_scheduler_unit uut (.*);

    mpts_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_op, .i_task_id,
        .i_run_time, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_out_valid(o_out_valid), .i_out_stall, .i_event_kind(o_event_kind),
        .i_task_ident(o_task_ident), .i_time_value(o_time_value),
        .i_occupancy(o_occupancy), .i_workers_free(o_workers_free), .i_last(o_last),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [15:0] id, logic [15:0] rt);
        logic stalled;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_task_id <= id;
        i_run_time <= rt;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        logic ready;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            ready = o_cfg_ready;
            @(posedge i_clk);
        end while (!ready);
    endtask

    task automatic set_config(logic [1:0] pol, logic [7:0] slice, logic [7:0] workers);
        wait_drained();
        write_reg(REG_POLICY, {6'd0, pol});
        write_reg(REG_SLICE_LENGTH, slice);
        write_reg(REG_WORKER_TOTAL, workers);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item(int max_rt);
        int r;
        r = $urandom_range(99);
        if (r < 45) send_item(OP_ARRIVE, 16'($urandom), 16'($urandom_range(0, max_rt)));
        else if (r < 78) send_item(OP_TICK, 16'($urandom), 16'($urandom));
        else if (r < 97) send_item(OP_DISPATCH, 16'($urandom), 16'($urandom));
        else send_item(OP_NOP, 16'($urandom), 16'($urandom));
    endtask

    task automatic empty_table();
        set_config(POL_RR, 8'd255, 8'd16);
        repeat (2) begin
            send_item(OP_DISPATCH, 16'd0, 16'd0);
            send_item(OP_TICK, 16'd0, 16'd0);
        end
    endtask

    logic [1:0] phase_pol  [8] = '{POL_FCFS, POL_SJF, POL_RR, POL_RR, POL_RR, POL_NONE,
                                   POL_SJF, POL_FCFS};
    logic [7:0] phase_slice[8] = '{8'd5, 8'd5, 8'd1, 8'd0, 8'd255, 8'd5, 8'd3, 8'd7};
    logic [7:0] phase_wk   [8] = '{8'd4, 8'd1, 8'd3, 8'd16, 8'd2, 8'd4, 8'd16, 8'd1};
    int idle_mode_a[4] = '{0, 57, 0, 19};
    int idle_mode_b[4] = '{0, 0, 57, 19};

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_ARRIVE, 16'h0000, 16'd0);
        send_item(OP_ARRIVE, 16'hFFFF, 16'd3);
        send_item(OP_ARRIVE, 16'h5A5A, 16'd2);
        send_item(OP_ARRIVE, 16'hA5A5, 16'd1);
        send_item(OP_ARRIVE, 16'd7, 16'd4);
        send_item(OP_DISPATCH, 16'd0, 16'd0);
        repeat (2) send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_DISPATCH, 16'd0, 16'd0);
        repeat (4) send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_NOP, 16'hFFFF, 16'hFFFF);
        send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_DISPATCH, 16'd0, 16'd0);
        wait_drained();
        write_reg(REG_UNUSED, 8'hFF);
        i_cfg_valid <= 1'b0;

        for (int p = 0; p < 8; p++) begin
            set_config(phase_pol[p], phase_slice[p], phase_wk[p]);
            send_idle_pct = idle_mode_a[p % 4];
            stall_pct = idle_mode_b[p % 4];
            if (p == 1) repeat (18) send_item(OP_ARRIVE, 16'($urandom), 16'($urandom_range(1, 6)));
            repeat (4) random_item(8);
            empty_table();
        end

        set_config(POL_RR, 8'd2, 8'd16);
        send_idle_pct = 19;
        stall_pct = 19;
        send_item(OP_ARRIVE, 16'hFFFF, 16'hFFFF);
        send_item(OP_ARRIVE, 16'h0000, 16'h8000);
        repeat (12) random_item(65535);
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/mpts_pkg.sv
rtl/core/mpts_ctrl.sv
rtl/core/mpts_dpath.sv
rtl/core/multi_policy_task_scheduler_unit.sv
tb/mpts_checker.sv
tb/multi_policy_task_scheduler_unit_tb.sv
